// File: rtl/glms_pkg.sv
package glms_pkg;

    localparam int ROWS    = 25;
    localparam int COLUMNS = 25;
    localparam int LEVELS  = 15;

    localparam int ROW_BYTES = (COLUMNS + 1) / 2;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int WORD_W    = ROW_BYTES * 8;

    // row select coding: low nibble below this row, high nibble from it on
    localparam int ROW_SPLIT   = 15;
    localparam int SEL_HI_OFS  = 14;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [7:0] BYTE_FULL = 8'hff;

    typedef logic [WORD_W-1:0]  t_row_word;
    typedef logic [COLUMNS-1:0] t_mask;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [3:0]       phase;
    } t_scan;

    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic [3:0]       wbyte;
        logic [7:0]       wdata;
        logic             re;
        logic [ROW_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [7:0] row_sel(input logic [ROW_W-1:0] r);
        logic [7:0] rx;
        logic [7:0] hi;
        rx = 8'(r);
        hi = rx - 8'(SEL_HI_OFS);
        if (rx < 8'(ROW_SPLIT)) begin
            return rx + 8'd1;
        end
        return {hi[3:0], 4'h0};
    endfunction

endpackage

// File: rtl/glms_in_if.sv
interface glms_in_if;
    import glms_pkg::*;

    logic       valid;
    logic       ready;
    logic       cmd;
    logic [4:0] row;
    logic [3:0] byte_index;
    logic [7:0] pixel_pair;

    modport source (output valid, output cmd, output row, output byte_index,
                    output pixel_pair, input ready);
    modport sink   (input valid, input cmd, input row, input byte_index,
                    input pixel_pair, output ready);
endinterface

// File: rtl/glms_out_if.sv
interface glms_out_if;
    import glms_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLUMNS-1:0] column_mask;
    logic [7:0]         row_select;
    logic [3:0]         phase;

    modport source (output valid, output column_mask, output row_select,
                    output phase, input ready);
    modport sink   (input valid, input column_mask, input row_select,
                    input phase, output ready);
endinterface

// File: rtl/glms_frame_mem.sv
module glms_frame_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  glms_pkg::t_mem_req  i_req,
    output glms_pkg::t_row_word o_rdata
);
    import glms_pkg::*;

    logic [WORD_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    t_row_word         r_q;
    logic              r_q_vld;
    logic              w_full;

    // first write into a row fills the other bytes with full brightness
    assign w_full = !r_row_vld[i_req.waddr];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < ROW_BYTES; b++) begin
            if (i_req.we && (w_full || i_req.wbyte == 4'(b))) begin
                r_mem[i_req.waddr][b*8 +: 8] <=
                    (i_req.wbyte == 4'(b)) ? i_req.wdata : BYTE_FULL;
            end
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_q_vld   <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_row_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_q_vld <= r_row_vld[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_q_vld ? r_q : {ROW_BYTES{BYTE_FULL}};

    a_no_rw_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.we && i_req.re))
        else $error("frame store read and write in the same cycle");

    a_row_marked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.we |=> r_row_vld[$past(i_req.waddr)])
        else $error("written row not marked valid");

endmodule

// File: rtl/glms_scan_seq.sv
module glms_scan_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    glms_in_if.sink            i_in,
    input  logic               i_s1_take,
    output logic               o_s1_vld,
    output glms_pkg::t_scan    o_s1,
    output glms_pkg::t_mem_req o_req
);
    import glms_pkg::*;

    logic [3:0]       r_phase;
    logic [ROW_W-1:0] r_row;
    logic             r_s1_vld;
    t_scan            r_s1;

    logic [3:0]       n_phase;
    logic [ROW_W-1:0] n_row;
    logic [3:0]       w_phase_inc;
    logic             w_wrap;
    logic             w_acc;
    logic             w_tick;
    logic             w_wr_ok;

    assign i_in.ready = !r_s1_vld || i_s1_take;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_tick     = w_acc && (i_in.cmd == CMD_TICK);
    assign w_wr_ok    = w_acc && (i_in.cmd == CMD_WRITE)
                        && (i_in.row < 5'(ROWS))
                        && ({1'b0, i_in.byte_index} < 5'(ROW_BYTES));

    assign w_phase_inc = r_phase + 4'd1;
    assign w_wrap      = (w_phase_inc >= 4'(LEVELS));

    always_comb begin
        n_phase = w_wrap ? 4'd0 : w_phase_inc;
        n_row   = r_row;
        if (w_wrap) begin
            n_row = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + ROW_W'(1);
        end
    end

    always_comb begin
        o_req.we    = w_wr_ok;
        o_req.waddr = i_in.row[ROW_W-1:0];
        o_req.wbyte = i_in.byte_index;
        o_req.wdata = i_in.pixel_pair;
        o_req.re    = w_tick;
        o_req.raddr = n_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 4'd0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (w_tick) begin
                r_phase  <= n_phase;
                r_row    <= n_row;
                r_s1_vld <= 1'b1;
            end else if (i_s1_take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1.phase <= n_phase;
            r_s1.row   <= n_row;
        end
    end

    assign o_s1_vld = r_s1_vld;
    assign o_s1     = r_s1;

    a_phase_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < 4'(LEVELS))
        else $error("duty phase out of range");

    a_row_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < ROWS)
        else $error("scan row out of range");

    a_tick_staged : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> r_s1_vld && (r_s1.phase == r_phase) && (r_s1.row == r_row))
        else $error("tick not staged with its phase and row");

endmodule

// File: rtl/glms_out_stage.sv
module glms_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s1_vld,
    input  glms_pkg::t_scan     i_s1,
    input  glms_pkg::t_row_word i_rdata,
    output logic                o_s1_take,
    glms_out_if.source          o_out
);
    import glms_pkg::*;

    logic       r_out_vld;
    t_mask      r_mask;
    logic [7:0] r_sel;
    logic [3:0] r_phase;
    t_mask      w_mask;
    logic       w_load;

    assign w_load    = i_s1_vld && (!r_out_vld || o_out.ready);
    assign o_s1_take = w_load;

    // nibble k of the row word is column k
    always_comb begin
        for (int k = 0; k < COLUMNS; k++) begin
            w_mask[k] = (i_rdata[k*4 +: 4] > i_s1.phase);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mask  <= w_mask;
            r_sel   <= row_sel(i_s1.row);
            r_phase <= i_s1.phase;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.column_mask = r_mask;
    assign o_out.row_select  = r_sel;
    assign o_out.phase       = r_phase;

    a_load_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_vld && (r_phase == $past(i_s1.phase)))
        else $error("loaded beat not presented");

    a_out_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_phase < 4'(LEVELS)))
        else $error("output phase out of range");

endmodule

// File: rtl/grayscale_led_matrix_scanner_core.sv
// grayscale led matrix row scanner
// i_in: command beats. cmd write stores one pixel-pair byte (low nibble even
// column) at row/byte_index of the frame store; writes outside the matrix are
// dropped. cmd tick advances the duty phase, wrapping into the next scan row,
// and produces one beat on o_out.
// o_out: column_mask (bit k on when column k is brighter than phase),
// row_select (decoder nibbles) and the phase used for the scan.
// pipeline: an accepted tick reads its frame store row into the read stage,
// then the compare result is registered in the output reg.
// throughput: one beat per cycle while o_out moves, ticks and writes mixed
// freely; the frame store has one row-wide read port and one byte-write port,
// and a write is visible to any tick accepted in a later cycle.
// a stalled o_out holds its beat; one more tick sits in the read stage, after
// which i_in.ready drops until o_out moves.
// reset: phase and row return to 0, every pixel reads as brightness 15 via
// per-row valid bits, so no clearing pass is needed and beats are taken at once.
module grayscale_led_matrix_scanner_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    glms_in_if.sink    i_in,
    glms_out_if.source o_out
);
    import glms_pkg::*;

    t_mem_req  w_req;
    t_row_word w_rdata;
    t_scan     w_s1;
    logic      w_s1_vld;
    logic      w_s1_take;

    glms_scan_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_s1_take (w_s1_take),
        .o_s1_vld  (w_s1_vld),
        .o_s1      (w_s1),
        .o_req     (w_req)
    );

    glms_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    glms_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1_vld  (w_s1_vld),
        .i_s1      (w_s1),
        .i_rdata   (w_rdata),
        .o_s1_take (w_s1_take),
        .o_out     (o_out)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import glms_pkg::*;

    localparam int N_RANDOM    = 900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        t_mask      mask;
        logic [7:0] sel;
        logic [3:0] phase;
    } scan_beat_t;

    typedef struct packed {
        logic       cmd;
        logic [4:0] row;
        logic [3:0] bidx;
        logic [7:0] pair;
        logic       typed;
        scan_beat_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    glms_in_if  in_if ();
    glms_out_if out_if ();

    grayscale_led_matrix_scanner_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow copy of the scanner state
    logic [7:0]      pix_store [ROWS][ROW_BYTES];
    logic [3:0]      duty;
    logic [ROW_W-1:0] scan_r;

    scan_beat_t scans_due [$];
    stim_row_t  stim_tab [$];

    int unsigned errors;
    int unsigned cycle_cnt;
    int unsigned ticks;
    int unsigned writes_dropped;
    int unsigned beats_checked;
    logic [ROWS-1:0] rows_seen;
    bit          send_burst;
    bit          recv_burst;

    initial begin
        clk = 1'b0;
    end

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        $display("[%0d] mismatch %s: want %h got %h", cycle_cnt, what, want, got);
    endtask

    // wait cycles before a beat; bursts switch idling off for a while
    function automatic int draw_wait(inout bit burst_mode);
        if ($urandom_range(0, 39) == 0) begin
            burst_mode = !burst_mode;
        end
        if (burst_mode) begin
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic bit advance_scan(input logic cmd, input logic [4:0] row,
                                        input logic [3:0] bidx, input logic [7:0] pair,
                                        output scan_beat_t beat);
        logic [7:0] pair_byte;
        logic [3:0] level;
        beat = '0;
        if (cmd == CMD_WRITE) begin
            if (row < ROWS && bidx < ROW_BYTES) begin
                pix_store[row][bidx] = pair;
            end else begin
                writes_dropped++;
            end
            return 1'b0;
        end
        ticks++;
        duty = duty + 4'd1;
        if (duty >= LEVELS) begin
            duty = '0;
            if (scan_r == ROW_W'(ROWS - 1)) begin
                scan_r = '0;
            end else begin
                scan_r = scan_r + 1'b1;
            end
        end
        rows_seen[scan_r] = 1'b1;
        for (int col = 0; col < COLUMNS; col++) begin
            pair_byte = pix_store[scan_r][col / 2];
            level = (col % 2 == 1) ? pair_byte[7:4] : pair_byte[3:0];
            beat.mask[col] = (level > duty);
        end
        if (scan_r < ROW_SPLIT) begin
            beat.sel = 8'(scan_r) + 8'd1;
        end else begin
            beat.sel = {4'(scan_r - SEL_HI_OFS), 4'h0};
        end
        beat.phase = duty;
        return 1'b1;
    endfunction

    task automatic send_beat(input stim_row_t s);
        scan_beat_t beat;
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.cmd        <= s.cmd;
        in_if.row        <= s.row;
        in_if.byte_index <= s.bidx;
        in_if.pixel_pair <= s.pair;
        do @(posedge clk); while (!in_if.ready);
        if (advance_scan(s.cmd, s.row, s.bidx, s.pair, beat)) begin
            if (s.typed) begin
                beat = s.want;
            end
            scans_due.push_back(beat);
        end
    endtask

    task automatic add_row(input logic cmd, input logic [4:0] row, input logic [3:0] bidx,
                           input logic [7:0] pair, input logic typed, input t_mask mask,
                           input logic [7:0] sel, input logic [3:0] phase);
        stim_row_t s;
        s.cmd        = cmd;
        s.row        = row;
        s.bidx       = bidx;
        s.pair       = pair;
        s.typed      = typed;
        s.want.mask  = mask;
        s.want.sel   = sel;
        s.want.phase = phase;
        stim_tab.push_back(s);
    endtask

    // cycle counter and run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats pending", cycle_cnt,
                     scans_due.size());
            $display("** grayscale_led_matrix_scanner_core: FAILED **");
            $finish;
        end
    end

    // result side: random stalls per beat
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_wait(recv_burst);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!out_if.valid);
        end
    end

    always @(posedge clk) begin
        scan_beat_t want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (scans_due.size() == 0) begin
                report_mismatch("unexpected beat, mask", '0, 32'(out_if.column_mask));
            end else begin
                want = scans_due.pop_front();
                beats_checked++;
                if (out_if.column_mask !== want.mask) begin
                    report_mismatch("column_mask", 32'(want.mask), 32'(out_if.column_mask));
                end
                if (out_if.row_select !== want.sel) begin
                    report_mismatch("row_select", 32'(want.sel), 32'(out_if.row_select));
                end
                if (out_if.phase !== want.phase) begin
                    report_mismatch("phase", 32'(want.phase), 32'(out_if.phase));
                end
            end
        end
    end

    initial begin
        stim_row_t s;
        int pick;
        errors         = 0;
        cycle_cnt      = 0;
        ticks          = 0;
        writes_dropped = 0;
        beats_checked  = 0;
        rows_seen      = '0;
        send_burst     = 1'b0;
        recv_burst     = 1'b0;
        duty           = '0;
        scan_r         = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int b = 0; b < ROW_BYTES; b++) begin
                pix_store[r][b] = BYTE_FULL;
            end
        end

        rst_n            <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.cmd        <= CMD_WRITE;
        in_if.row        <= '0;
        in_if.byte_index <= '0;
        in_if.pixel_pair <= '0;

        // first tick after reset: full store, row 0 at phase 1
        add_row(CMD_TICK, 5'd0, 4'd0, 8'h00, 1'b1, 25'h1ffffff, 8'h01, 4'd1);
        add_row(CMD_WRITE, 5'd0, 4'd0, 8'h00, 1'b0, '0, '0, '0);
        // last byte of a row: high nibble is stored but never shown
        add_row(CMD_WRITE, 5'd0, 4'd12, 8'hf0, 1'b0, '0, '0, '0);
        add_row(CMD_WRITE, 5'd24, 4'd12, 8'h5a, 1'b0, '0, '0, '0);
        add_row(CMD_WRITE, 5'd12, 4'd6, 8'hff, 1'b0, '0, '0, '0);
        // writes outside the matrix are dropped
        add_row(CMD_WRITE, 5'd31, 4'd0, 8'h00, 1'b0, '0, '0, '0);
        add_row(CMD_WRITE, 5'd0, 4'd15, 8'h00, 1'b0, '0, '0, '0);
        add_row(CMD_WRITE, 5'd25, 4'd13, 8'h00, 1'b0, '0, '0, '0);
        add_row(CMD_TICK, 5'd31, 4'd15, 8'hff, 1'b1, 25'h0fffffc, 8'h01, 4'd2);
        add_row(CMD_WRITE, 5'd0, 4'd5, 8'h7e, 1'b0, '0, '0, '0);
        add_row(CMD_WRITE, 5'd1, 4'd0, 8'h0f, 1'b0, '0, '0, '0);
        // run row 0 up to phase 14, then wrap into row 1
        for (int k = 0; k < 12; k++) begin
            add_row(CMD_TICK, 5'd0, 4'd0, 8'h00, 1'b0, '0, '0, '0);
        end
        add_row(CMD_TICK, 5'd0, 4'd0, 8'h00, 1'b1, 25'h1fffffd, 8'h02, 4'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_tab[i]) begin
            send_beat(stim_tab[i]);
        end

        s.typed = 1'b0;
        s.want  = '0;
        for (int i = 0; i < N_RANDOM; i++) begin
            pick   = $urandom_range(0, 99);
            s.row  = 5'($urandom_range(0, ROWS - 1));
            s.bidx = 4'($urandom_range(0, ROW_BYTES - 1));
            s.pair = 8'($urandom_range(0, 255));
            if (pick < 48) begin
                s.cmd  = CMD_TICK;
                s.row  = 5'($urandom_range(0, 31));
                s.bidx = 4'($urandom_range(0, 15));
            end else if (pick < 88) begin
                s.cmd = CMD_WRITE;
                // favor the row being scanned so new data shows up soon
                if (pick < 60) begin
                    s.row = 5'(scan_r);
                end
            end else begin
                s.cmd  = CMD_WRITE;
                s.row  = 5'($urandom_range(0, 31));
                s.bidx = 4'($urandom_range(0, 15));
            end
            send_beat(s);
        end
        in_if.valid <= 1'b0;

        while (scans_due.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (scans_due.size() != 0) begin
            report_mismatch("beats never seen", '0, 32'(scans_due.size()));
        end

        $display("covered %0d items: %0d ticks, %0d beats checked, %0d writes dropped",
                 stim_tab.size() + N_RANDOM, ticks, beats_checked, writes_dropped);
        $display("scan rows visited: %b, mismatches: %0d", rows_seen, errors);
        if (errors == 0) begin
            $display("** grayscale_led_matrix_scanner_core: PASSED **");
        end else begin
            $display("** grayscale_led_matrix_scanner_core: FAILED **");
        end
        $finish;
    end

endmodule
